[hw/rtl/assert_macros.svh]
// Assertion macros for the checker of the reference count table.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RCT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define RCT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rct_pkg.sv]
// Shared types and codes of the reference count table.
// Depends on nothing; used by the controller, the datapath, the top level and the checker.
package rct_pkg;

    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam int PORT_HANDLE_W = 32;
    localparam int PORT_COUNT_W  = 16;
    localparam int PORT_TALLY_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ASSIGN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic apply_old;
        logic apply_new;
        logic finish;
    } rct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic is_assign;
    } rct_stat_t;

endpackage

[hw/rtl/reference_count_table_core.sv]
// Reference count table. A command beat is taken at a rising edge where start is high and
// busy is low; its result beat appears on the result ports for exactly one cycle, marked
// by done, and must be taken in that cycle because the block cannot hold it. Register and
// assign commands scan the whole table once, one slot per cycle through a single read port
// of the handle and count memories, comparing each slot against the old handle, the new
// handle and the free-slot search at the same time. After the accepting edge, an assign
// passes through the scan, a drain step, a write step for the old handle, one for the new
// handle and a result step before done rises; a register skips the step for the new
// handle, and a clear or an unused action goes straight to the result step. busy falls
// with done, so the next command beat may be taken at the edge that ends the done cycle.
// A register of the null handle and an unused action skip the scan. Valid bits sit in
// flip-flops, so reset and a clear empty the table at once with no clearing pass.
// Depends on rct_pkg, rct_ctrl and rct_datapath.
module reference_count_table_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int HANDLE_BITS = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic [rct_pkg::ACTION_W-1:0]      action,
    input  logic [rct_pkg::PORT_HANDLE_W-1:0] old_handle,
    input  logic [rct_pkg::PORT_HANDLE_W-1:0] new_handle,
    output logic [rct_pkg::STATUS_W-1:0]      status,
    output logic                              released,
    output logic [rct_pkg::PORT_HANDLE_W-1:0] released_handle,
    output logic [rct_pkg::PORT_TALLY_W-1:0]  released_count,
    output logic                              old_found,
    output logic                              new_found,
    output logic [rct_pkg::PORT_COUNT_W-1:0]  new_count,
    output logic [rct_pkg::PORT_TALLY_W-1:0]  live_entries
);

    // The controller sequences the scan and the write cycles; the datapath holds the table.
    rct_pkg::rct_cmd_t  cmd;
    rct_pkg::rct_stat_t st;

    rct_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Handles are kept to HANDLE_BITS bits; counts saturate at all ones of COUNT_BITS.
    rct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .action          (action),
        .old_handle      (old_handle),
        .new_handle      (new_handle),
        .status          (status),
        .released        (released),
        .released_handle (released_handle),
        .released_count  (released_count),
        .old_found       (old_found),
        .new_found       (new_found),
        .new_count       (new_count),
        .live_entries    (live_entries)
    );

endmodule

[hw/rtl/rct_ctrl.sv]
// Controller state machine of the reference count table.
// Depends on rct_pkg; drives the datapath through rct_cmd_t and watches rct_stat_t.
module rct_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rct_pkg::rct_stat_t st,
    output rct_pkg::rct_cmd_t  cmd,
    output logic              busy,
    output logic              done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WR_OLD,
        S_WR_NEW,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = st.need_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (st.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_WR_OLD;
            S_WR_OLD: state_next = st.is_assign ? S_WR_NEW : S_FINISH;
            S_WR_NEW: state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && start;
        cmd.scan_rd   = (state_reg == S_SCAN);
        cmd.apply_old = (state_reg == S_WR_OLD);
        cmd.apply_new = (state_reg == S_WR_NEW);
        cmd.finish    = (state_reg == S_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_reg == S_FINISH);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

[hw/rtl/rct_datapath.sv]
// Datapath of the reference count table: handle and count memories, valid bits,
// the scan trackers, the update logic and the result registers. Depends on rct_pkg.
module rct_datapath #(
    parameter int TABLE_DEPTH = 64,
    parameter int HANDLE_BITS = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rct_pkg::rct_cmd_t                   cmd,
    output rct_pkg::rct_stat_t                  st,
    input  logic [rct_pkg::ACTION_W-1:0]        action,
    input  logic [rct_pkg::PORT_HANDLE_W-1:0]   old_handle,
    input  logic [rct_pkg::PORT_HANDLE_W-1:0]   new_handle,
    output logic [rct_pkg::STATUS_W-1:0]        status,
    output logic                                released,
    output logic [rct_pkg::PORT_HANDLE_W-1:0]   released_handle,
    output logic [rct_pkg::PORT_TALLY_W-1:0]    released_count,
    output logic                                old_found,
    output logic                                new_found,
    output logic [rct_pkg::PORT_COUNT_W-1:0]    new_count,
    output logic [rct_pkg::PORT_TALLY_W-1:0]    live_entries
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LIVE_W = $clog2(TABLE_DEPTH + 1);
    localparam int KEEP_W = (HANDLE_BITS < rct_pkg::PORT_HANDLE_W) ? HANDLE_BITS
                                                                     : rct_pkg::PORT_HANDLE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [KEEP_W-1:0]     hnd_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] cnt_mem [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [LIVE_W-1:0]      live_reg;
    logic [IDX_W-1:0]       addr_reg;
    logic                   rd_pend_reg;
    logic                   rd_vld_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [KEEP_W-1:0]      rd_hnd_reg;
    logic [COUNT_BITS-1:0]  rd_cnt_reg;

    logic [rct_pkg::ACTION_W-1:0] act_reg;
    logic [KEEP_W-1:0]            oldh_reg;
    logic [KEEP_W-1:0]            newh_reg;

    logic                  old_hit_reg;
    logic                  new_hit_reg;
    logic                  free_hit_reg;
    logic [IDX_W-1:0]      old_slot_reg;
    logic [IDX_W-1:0]      new_slot_reg;
    logic [IDX_W-1:0]      free_slot_reg;
    logic [COUNT_BITS-1:0] old_cnt_reg;
    logic [COUNT_BITS-1:0] new_cnt_reg;
    logic [COUNT_BITS-1:0] old_dec_reg;
    logic [COUNT_BITS-1:0] new_res_reg;
    logic                  removed_reg;
    logic                  new_ok_reg;
    logic                  sat_reg;

    logic [rct_pkg::STATUS_W-1:0]      status_reg;
    logic                              released_reg;
    logic [rct_pkg::PORT_HANDLE_W-1:0] released_handle_reg;
    logic [rct_pkg::PORT_TALLY_W-1:0]  released_count_reg;
    logic                              old_found_reg;
    logic                              new_found_reg;
    logic [rct_pkg::PORT_COUNT_W-1:0]  new_count_reg;
    logic [rct_pkg::PORT_TALLY_W-1:0]  live_entries_reg;

    logic [rct_pkg::STATUS_W-1:0]      status_next;
    logic                              released_next;
    logic [rct_pkg::PORT_HANDLE_W-1:0] released_handle_next;
    logic [rct_pkg::PORT_TALLY_W-1:0]  released_count_next;
    logic                              old_found_next;
    logic                              new_found_next;
    logic [rct_pkg::PORT_COUNT_W-1:0]  new_count_next;
    logic [rct_pkg::PORT_TALLY_W-1:0]  live_entries_next;

    logic                  old_match;
    logic                  new_match;
    logic                  free_match;
    logic [COUNT_BITS-1:0] old_dec;
    logic                  same_slot;
    logic [COUNT_BITS-1:0] new_base;
    logic                  new_live_ok;
    logic                  new_sat;
    logic [COUNT_BITS-1:0] new_inc;
    logic                  reg_new;

    logic                  we_hnd;
    logic                  we_cnt;
    logic [IDX_W-1:0]      waddr;
    logic [COUNT_BITS-1:0] wcnt;

    assign st.need_scan = ((action == rct_pkg::ACT_REGISTER) && (new_handle[KEEP_W-1:0] != '0))
                          || (action == rct_pkg::ACT_ASSIGN);
    assign st.scan_last = (addr_reg == LAST_IDX);
    assign st.is_assign = (act_reg == rct_pkg::ACT_ASSIGN);

    // Each slot read during the scan is compared against both handles at once.
    assign old_match  = rd_pend_reg && rd_vld_reg && (rd_hnd_reg == oldh_reg)
                        && (oldh_reg != '0) && !old_hit_reg;
    assign new_match  = rd_pend_reg && rd_vld_reg && (rd_hnd_reg == newh_reg)
                        && (newh_reg != '0) && !new_hit_reg;
    assign free_match = rd_pend_reg && !rd_vld_reg && !free_hit_reg;

    assign old_dec     = old_cnt_reg - COUNT_BITS'(1);
    assign same_slot   = old_hit_reg && new_hit_reg && (old_slot_reg == new_slot_reg);
    assign new_base    = same_slot ? old_dec_reg : new_cnt_reg;
    assign new_live_ok = new_hit_reg && !(same_slot && removed_reg);
    assign new_sat     = (new_base == '1);
    assign new_inc     = new_base + COUNT_BITS'(1);
    assign reg_new     = (newh_reg != '0);

    always_comb
    begin
        we_hnd = 1'b0;
        we_cnt = 1'b0;
        waddr  = '0;
        wcnt   = '0;
        if (cmd.apply_old)
        begin
            if ((act_reg == rct_pkg::ACT_REGISTER) && !new_hit_reg && free_hit_reg)
            begin
                we_hnd = 1'b1;
                we_cnt = 1'b1;
                waddr  = free_slot_reg;
                wcnt   = COUNT_BITS'(1);
            end
            else if ((act_reg == rct_pkg::ACT_ASSIGN) && old_hit_reg)
            begin
                we_cnt = 1'b1;
                waddr  = old_slot_reg;
                wcnt   = old_dec;
            end
        end
        if (cmd.apply_new && new_live_ok && !new_sat)
        begin
            we_cnt = 1'b1;
            waddr  = new_slot_reg;
            wcnt   = new_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            rd_hnd_reg <= hnd_mem[addr_reg];
            rd_cnt_reg <= cnt_mem[addr_reg];
        end
        if (we_hnd)
        begin
            hnd_mem[waddr] <= newh_reg;
        end
        if (we_cnt)
        begin
            cnt_mem[waddr] <= wcnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            live_reg     <= '0;
            addr_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            old_hit_reg  <= 1'b0;
            new_hit_reg  <= 1'b0;
            free_hit_reg <= 1'b0;
            removed_reg  <= 1'b0;
            new_ok_reg   <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_rd;
            if (cmd.load)
            begin
                addr_reg     <= '0;
                old_hit_reg  <= 1'b0;
                new_hit_reg  <= 1'b0;
                free_hit_reg <= 1'b0;
                removed_reg  <= 1'b0;
                new_ok_reg   <= 1'b0;
                sat_reg      <= 1'b0;
            end
            if (cmd.scan_rd)
            begin
                rd_vld_reg <= valid_reg[addr_reg];
                rd_idx_reg <= addr_reg;
                addr_reg   <= addr_reg + IDX_W'(1);
            end
            if (old_match)
            begin
                old_hit_reg <= 1'b1;
            end
            if (new_match)
            begin
                new_hit_reg <= 1'b1;
            end
            if (free_match)
            begin
                free_hit_reg <= 1'b1;
            end
            if (cmd.apply_old)
            begin
                if ((act_reg == rct_pkg::ACT_REGISTER) && !new_hit_reg && free_hit_reg)
                begin
                    valid_reg[free_slot_reg] <= 1'b1;
                    live_reg                 <= live_reg + LIVE_W'(1);
                end
                else if ((act_reg == rct_pkg::ACT_ASSIGN) && old_hit_reg && (old_dec == '0))
                begin
                    valid_reg[old_slot_reg] <= 1'b0;
                    live_reg                <= live_reg - LIVE_W'(1);
                    removed_reg             <= 1'b1;
                end
            end
            if (cmd.apply_new)
            begin
                new_ok_reg <= new_live_ok;
                sat_reg    <= new_live_ok && new_sat;
            end
            if (cmd.finish && (act_reg == rct_pkg::ACT_CLEAR))
            begin
                valid_reg <= '0;
                live_reg  <= '0;
            end
        end
    end

    always_comb
    begin
        status_next          = rct_pkg::ST_OK;
        released_next        = 1'b0;
        released_handle_next = '0;
        released_count_next  = '0;
        old_found_next       = 1'b0;
        new_found_next       = 1'b0;
        new_count_next       = '0;
        live_entries_next    = rct_pkg::PORT_TALLY_W'(live_reg);
        unique case (act_reg)
            rct_pkg::ACT_REGISTER:
            begin
                if (reg_new && new_hit_reg)
                begin
                    status_next    = rct_pkg::ST_DUP;
                    new_found_next = 1'b1;
                    new_count_next = rct_pkg::PORT_COUNT_W'(new_cnt_reg);
                end
                else if (reg_new && free_hit_reg)
                begin
                    new_found_next = 1'b1;
                    new_count_next = rct_pkg::PORT_COUNT_W'(1);
                end
                else if (reg_new)
                begin
                    status_next = rct_pkg::ST_FULL;
                end
            end
            rct_pkg::ACT_ASSIGN:
            begin
                status_next          = sat_reg ? rct_pkg::ST_SAT : rct_pkg::ST_OK;
                released_next        = removed_reg;
                released_handle_next = removed_reg ? rct_pkg::PORT_HANDLE_W'(oldh_reg) : '0;
                released_count_next  = rct_pkg::PORT_TALLY_W'(removed_reg);
                old_found_next       = old_hit_reg;
                new_found_next       = new_ok_reg;
                new_count_next       = new_ok_reg ? rct_pkg::PORT_COUNT_W'(new_res_reg) : '0;
            end
            rct_pkg::ACT_CLEAR:
            begin
                released_count_next = rct_pkg::PORT_TALLY_W'(live_reg);
                live_entries_next   = '0;
            end
            default:
            begin
                status_next = rct_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            oldh_reg <= old_handle[KEEP_W-1:0];
            newh_reg <= new_handle[KEEP_W-1:0];
        end
        if (old_match)
        begin
            old_slot_reg <= rd_idx_reg;
            old_cnt_reg  <= rd_cnt_reg;
        end
        if (new_match)
        begin
            new_slot_reg <= rd_idx_reg;
            new_cnt_reg  <= rd_cnt_reg;
        end
        if (free_match)
        begin
            free_slot_reg <= rd_idx_reg;
        end
        if (cmd.apply_old)
        begin
            old_dec_reg <= old_dec;
        end
        if (cmd.apply_new)
        begin
            new_res_reg <= new_sat ? new_base : new_inc;
        end
        if (cmd.finish)
        begin
            status_reg          <= status_next;
            released_reg        <= released_next;
            released_handle_reg <= released_handle_next;
            released_count_reg  <= released_count_next;
            old_found_reg       <= old_found_next;
            new_found_reg       <= new_found_next;
            new_count_reg       <= new_count_next;
            live_entries_reg    <= live_entries_next;
        end
    end

    assign status          = status_reg;
    assign released        = released_reg;
    assign released_handle = released_handle_reg;
    assign released_count  = released_count_reg;
    assign old_found       = old_found_reg;
    assign new_found       = new_found_reg;
    assign new_count       = new_count_reg;
    assign live_entries    = live_entries_reg;

endmodule

[hw/rtl/rct_checker.sv]
// Port-level checker of the reference count table, bound to the top level.
// Depends on rct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rct_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [rct_pkg::STATUS_W-1:0]      status,
    input logic                              released,
    input logic [rct_pkg::PORT_HANDLE_W-1:0] released_handle,
    input logic [rct_pkg::PORT_TALLY_W-1:0]  released_count,
    input logic                              old_found,
    input logic                              new_found
);

    `RCT_CHECK(a_done_not_busy, done |-> !busy, "result beat while busy")
    `RCT_CHECK_NEXT(a_accept_holds, start && !busy, busy && !done, "accepted beat not held busy")
    `RCT_CHECK(a_release_found, done && released |-> old_found && released_count == 7'd1, "release without a found old handle")
    `RCT_CHECK(a_dup_found, done && status == rct_pkg::ST_DUP |-> new_found, "duplicate status without a found handle")
    `RCT_CHECK(a_handle_flag, done && released_handle != '0 |-> released, "released handle without release flag")

endmodule

bind reference_count_table_core rct_checker u_rct_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .released        (released),
    .released_handle (released_handle),
    .released_count  (released_count),
    .old_found       (old_found),
    .new_found       (new_found)
);

[tb/tb_top.sv]
// Self-checking testbench for reference_count_table_core: a directed table of commands, then
// random register/assign/clear traffic under several sender idle rates, checked by a table model.
// Depends on rct_pkg and reference_count_table_core.
module tb_top;

    // Geometry of the block under test, as instantiated with its default parameters.
    localparam int SLOTS = 64;

    // Random command beats per idle phase, and the number of idle phases.
    localparam int BEATS_PER_PHASE = 430;
    localparam int NUM_PHASES = 3;

    // Cycles without any accepted beat, either side, before the run is declared hung.
    // A command takes one scan of the table plus its write and result steps, so this is far beyond any correct wait.
    localparam int HANG_LIMIT = 3000;

    // One result beat, in the order of the result ports.
    typedef struct packed {
        logic [rct_pkg::STATUS_W-1:0]      status;
        logic                              released;
        logic [rct_pkg::PORT_HANDLE_W-1:0] rel_handle;
        logic [rct_pkg::PORT_TALLY_W-1:0]  rel_count;
        logic                              old_found;
        logic                              new_found;
        logic [rct_pkg::PORT_COUNT_W-1:0]  new_count;
        logic [rct_pkg::PORT_TALLY_W-1:0]  live;
    } outcome_t;

    // One row of the directed script. Rows with typed set carry a hand-written outcome.
    typedef struct {
        logic [rct_pkg::ACTION_W-1:0]      act;
        logic [rct_pkg::PORT_HANDLE_W-1:0] old_h;
        logic [rct_pkg::PORT_HANDLE_W-1:0] new_h;
        logic                              typed;
        outcome_t                          want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                              start = 1'b0;
    logic [rct_pkg::ACTION_W-1:0]      action = '0;
    logic [rct_pkg::PORT_HANDLE_W-1:0] old_handle = '0;
    logic [rct_pkg::PORT_HANDLE_W-1:0] new_handle = '0;

    logic                              busy;
    logic                              done;
    logic [rct_pkg::STATUS_W-1:0]      status;
    logic                              released;
    logic [rct_pkg::PORT_HANDLE_W-1:0] released_handle;
    logic [rct_pkg::PORT_TALLY_W-1:0]  released_count;
    logic                              old_found;
    logic                              new_found;
    logic [rct_pkg::PORT_COUNT_W-1:0]  new_count;
    logic [rct_pkg::PORT_TALLY_W-1:0]  live_entries;

    // Side information that travels with the command beat: a typed outcome, when the
    // script row has one. Driven with nonblocking assignments, just like the ports.
    logic     beat_typed = 1'b0;
    outcome_t beat_want = '0;

    // Model of the table: valid bits, handles and counts per slot, and the live total.
    logic                              tbl_valid [SLOTS];
    logic [rct_pkg::PORT_HANDLE_W-1:0] tbl_handle [SLOTS];
    logic [rct_pkg::PORT_COUNT_W-1:0]  tbl_count [SLOTS];
    int                                live_n = 0;

    // Outcomes owed by the block, oldest first.
    outcome_t owed_outcomes [$];

    int errors = 0;
    int idle_pct = 0;
    int stall_cycles = 0;

    // Tallies for the closing summary.
    int n_by_action [4] = '{0, 0, 0, 0};
    int n_full = 0;
    int n_dup = 0;
    int n_release = 0;
    int n_cleared = 0;
    int peak_live = 0;
    int n_checked = 0;

    script_row_t script [$];

    reference_count_table_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .action          (action),
        .old_handle      (old_handle),
        .new_handle      (new_handle),
        .status          (status),
        .released        (released),
        .released_handle (released_handle),
        .released_count  (released_count),
        .old_found       (old_found),
        .new_found       (new_found),
        .new_count       (new_count),
        .live_entries    (live_entries)
    );

    always #4 clk = ~clk;

    initial
    begin
        foreach (tbl_valid[i])
        begin
            tbl_valid[i] = 1'b0;
            tbl_handle[i] = '0;
            tbl_count[i] = '0;
        end
    end

    // Sender idle rate of each phase in percent.
    function automatic int phase_idle(input int p);
        case (p)
            0: return 0;
            1: return 68;
            default: return 11;
        endcase
    endfunction

    function automatic int find_handle(input logic [rct_pkg::PORT_HANDLE_W-1:0] h);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && tbl_handle[i] == h)
                return i;
        return -1;
    endfunction

    // Applies one accepted command to the table model and returns the outcome it owes.
    // An assignment decrements the old handle first, so a self assignment that drops the
    // count to zero removes the entry and then finds the new handle untracked.
    task automatic update_table(input logic [rct_pkg::ACTION_W-1:0] act,
                                input logic [rct_pkg::PORT_HANDLE_W-1:0] old_h,
                                input logic [rct_pkg::PORT_HANDLE_W-1:0] new_h,
                                output outcome_t res);
        int hit;
        int hole;
        res = '0;
        case (act)
            rct_pkg::ACT_REGISTER:
            begin
                // The null handle is ignored. A duplicate is rejected before fullness counts.
                if (new_h != '0)
                begin
                    hit = -1;
                    hole = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                    begin
                        if (tbl_valid[i] && tbl_handle[i] == new_h)
                            hit = i;
                        if (!tbl_valid[i])
                            hole = i;
                    end
                    if (hit >= 0)
                    begin
                        res.status = rct_pkg::ST_DUP;
                        res.new_found = 1'b1;
                        res.new_count = tbl_count[hit];
                    end
                    else if (hole < 0)
                        res.status = rct_pkg::ST_FULL;
                    else
                    begin
                        tbl_valid[hole] = 1'b1;
                        tbl_handle[hole] = new_h;
                        tbl_count[hole] = rct_pkg::PORT_COUNT_W'(1);
                        live_n++;
                        res.new_found = 1'b1;
                        res.new_count = rct_pkg::PORT_COUNT_W'(1);
                    end
                end
            end
            rct_pkg::ACT_ASSIGN:
            begin
                if (old_h != '0)
                begin
                    hit = find_handle(old_h);
                    if (hit >= 0)
                    begin
                        res.old_found = 1'b1;
                        tbl_count[hit] = tbl_count[hit] - 1'b1;
                        if (tbl_count[hit] == '0)
                        begin
                            tbl_valid[hit] = 1'b0;
                            live_n--;
                            res.released = 1'b1;
                            res.rel_handle = old_h;
                            res.rel_count = rct_pkg::PORT_TALLY_W'(1);
                        end
                    end
                end
                if (new_h != '0)
                begin
                    hit = find_handle(new_h);
                    if (hit >= 0)
                    begin
                        res.new_found = 1'b1;
                        // A count at its ceiling stays there and flags saturation.
                        if (tbl_count[hit] == '1)
                            res.status = rct_pkg::ST_SAT;
                        else
                            tbl_count[hit] = tbl_count[hit] + 1'b1;
                        res.new_count = tbl_count[hit];
                    end
                end
            end
            rct_pkg::ACT_CLEAR:
            begin
                res.rel_count = rct_pkg::PORT_TALLY_W'(live_n);
                foreach (tbl_valid[i])
                    tbl_valid[i] = 1'b0;
                live_n = 0;
            end
            default:
            begin
            end
        endcase
        res.live = rct_pkg::PORT_TALLY_W'(live_n);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // The monitor. Both handshakes are sampled at the rising edge, so it sees the values
    // that were in place during the cycle that the edge ends. The result beat is checked
    // before a command beat taken at the same edge is added to the owed outcomes.
    always @(posedge clk)
    begin : monitor
        outcome_t got;
        outcome_t want;
        outcome_t model;
        if (rst_n)
        begin
            if (done)
            begin
                got.status = status;
                got.released = released;
                got.rel_handle = released_handle;
                got.rel_count = released_count;
                got.old_found = old_found;
                got.new_found = new_found;
                got.new_count = new_count;
                got.live = live_entries;
                if (owed_outcomes.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected, actual %0h",
                             $time, got);
                end
                else
                begin
                    want = owed_outcomes.pop_front();
                    n_checked++;
                    check_field("status", want.status, got.status);
                    check_field("released", want.released, got.released);
                    check_field("released_handle", want.rel_handle, got.rel_handle);
                    check_field("released_count", want.rel_count, got.rel_count);
                    check_field("old_found", want.old_found, got.old_found);
                    check_field("new_found", want.new_found, got.new_found);
                    check_field("new_count", want.new_count, got.new_count);
                    check_field("live_entries", want.live, got.live);
                end
            end
            if (start && !busy)
            begin
                update_table(action, old_handle, new_handle, model);
                // The model always runs so that its table tracks the block; a script row
                // with a typed outcome is checked against that outcome instead.
                owed_outcomes.push_back(beat_typed ? beat_want : model);
                n_by_action[action]++;
                if (model.status == rct_pkg::ST_FULL)
                    n_full++;
                if (model.status == rct_pkg::ST_DUP)
                    n_dup++;
                if (model.released)
                    n_release++;
                if (action == rct_pkg::ACT_CLEAR)
                    n_cleared += model.rel_count;
                if (live_n > peak_live)
                    peak_live = live_n;
            end
        end
    end

    // Presents one command beat and holds it until the block takes it. The sender may idle
    // first. After the accepting edge start drops, and the task waits on the clock again so that the
    // monitor has folded this beat into the table before the next beat is formed.
    task automatic send_beat(input logic [rct_pkg::ACTION_W-1:0] act,
                             input logic [rct_pkg::PORT_HANDLE_W-1:0] old_h,
                             input logic [rct_pkg::PORT_HANDLE_W-1:0] new_h,
                             input logic typed, input outcome_t want);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1'b1;
        action <= act;
        old_handle <= old_h;
        new_handle <= new_h;
        beat_typed <= typed;
        beat_want <= want;
        do
            @(posedge clk);
        while (!(start && !busy));
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Picks a handle: a tracked one with the given chance, otherwise mostly a fresh random
    // one, now and then null or a corner value.
    function automatic logic [rct_pkg::PORT_HANDLE_W-1:0] pick_handle(input int tracked_pct);
        logic [rct_pkg::PORT_HANDLE_W-1:0] pool [$];
        int roll;
        roll = $urandom_range(99);
        foreach (tbl_valid[i])
            if (tbl_valid[i])
                pool.push_back(tbl_handle[i]);
        if (roll < tracked_pct)
            return pool.size() > 0 ? pool[$urandom_range(pool.size() - 1)] : $urandom();
        if (roll < tracked_pct + 8)
            return '0;
        if (roll < tracked_pct + 12)
        begin
            case ($urandom_range(2))
                0: return 32'hFFFF_FFFF;
                1: return 32'h0000_0001;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom();
    endfunction

    function automatic script_row_t row_typed(input logic [rct_pkg::ACTION_W-1:0] act,
        input logic [rct_pkg::PORT_HANDLE_W-1:0] old_h,
        input logic [rct_pkg::PORT_HANDLE_W-1:0] new_h,
        input logic [rct_pkg::STATUS_W-1:0] st, input int rel,
        input logic [rct_pkg::PORT_HANDLE_W-1:0] rh,
        input int rc, input int of, input int nf, input int nc, input int live);
        script_row_t r;
        r.act = act;
        r.old_h = old_h;
        r.new_h = new_h;
        r.typed = 1'b1;
        r.want.status = st;
        r.want.released = 1'(rel);
        r.want.rel_handle = rh;
        r.want.rel_count = rct_pkg::PORT_TALLY_W'(rc);
        r.want.old_found = 1'(of);
        r.want.new_found = 1'(nf);
        r.want.new_count = rct_pkg::PORT_COUNT_W'(nc);
        r.want.live = rct_pkg::PORT_TALLY_W'(live);
        return r;
    endfunction

    function automatic script_row_t row_model(input logic [rct_pkg::ACTION_W-1:0] act,
        input logic [rct_pkg::PORT_HANDLE_W-1:0] old_h,
        input logic [rct_pkg::PORT_HANDLE_W-1:0] new_h);
        script_row_t r;
        r.act = act;
        r.old_h = old_h;
        r.new_h = new_h;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // Stimulus and end of run.
    initial
    begin : stimulus
        logic [rct_pkg::ACTION_W-1:0]      act;
        logic [rct_pkg::PORT_HANDLE_W-1:0] old_h;
        logic [rct_pkg::PORT_HANDLE_W-1:0] new_h;
        logic                              grow;
        int                                roll;

        // Directed part, starting from an empty table. Columns of a typed row: status,
        // released, released handle, released count, old found, new found, new count, live.
        // Unused action and clear on an empty table report nothing.
        script.push_back(row_typed(rct_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(row_typed(rct_pkg::ACT_CLEAR, 0, 0,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0));
        // Registering null is ignored.
        script.push_back(row_typed(rct_pkg::ACT_REGISTER, 0, 0,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0));
        script.push_back(row_typed(rct_pkg::ACT_REGISTER, 0, 32'hFFFF_FFFF,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 1, 1, 1));
        script.push_back(row_typed(rct_pkg::ACT_REGISTER, 0, 32'h0000_0001,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 1, 1, 2));
        // A handle already tracked is rejected.
        script.push_back(row_typed(rct_pkg::ACT_REGISTER, 0, 32'hFFFF_FFFF,
                                   rct_pkg::ST_DUP, 0, 0, 0, 0, 1, 1, 2));
        // Null old handle: only the increment happens.
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 0, 32'hFFFF_FFFF,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 1, 2, 2));
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 32'hFFFF_FFFF, 32'h0000_0001,
                                   rct_pkg::ST_OK, 0, 0, 0, 1, 1, 2, 2));
        // Self assignment that keeps the entry alive.
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 32'h0000_0001, 32'h0000_0001,
                                   rct_pkg::ST_OK, 0, 0, 0, 1, 1, 2, 2));
        // Self assignment that drops the count to zero: removed, then found untracked.
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   rct_pkg::ST_OK, 1, 32'hFFFF_FFFF, 1, 1, 0, 0, 1));
        // Untracked handles on both sides are skipped silently, and so are nulls.
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 32'hDEAD_BEEF, 32'h1234_5678,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 0, 0,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
        script.push_back(row_typed(rct_pkg::ACT_REGISTER, 0, 32'h8000_0000,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 1, 1, 2));
        script.push_back(row_typed(rct_pkg::ACT_REGISTER, 0, 32'h7FFF_FFFF,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 1, 1, 3));
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 32'h0000_0001, 32'h8000_0000,
                                   rct_pkg::ST_OK, 0, 0, 0, 1, 1, 2, 3));
        // The last reference goes away with a null new handle.
        script.push_back(row_typed(rct_pkg::ACT_ASSIGN, 32'h0000_0001, 0,
                                   rct_pkg::ST_OK, 1, 32'h0000_0001, 1, 1, 0, 0, 2));
        script.push_back(row_typed(rct_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                   rct_pkg::ST_OK, 0, 0, 2, 0, 0, 0, 0));
        script.push_back(row_model(rct_pkg::ACT_REGISTER, 0, 32'h5555_5555));
        script.push_back(row_model(rct_pkg::ACT_REGISTER, 32'hFFFF_FFFF, 32'hAAAA_AAAA));
        script.push_back(row_model(rct_pkg::ACT_ASSIGN, 32'hAAAA_AAAA, 32'h5555_5555));
        script.push_back(row_model(rct_pkg::ACT_ASSIGN, 32'h5555_5555, 32'h5555_5555));
        script.push_back(row_typed(rct_pkg::ACT_NONE, 32'h5555_5555, 32'h5555_5555,
                                   rct_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
        script.push_back(row_model(rct_pkg::ACT_REGISTER, 32'h1234_5678, 32'h5555_5555));
        script.push_back(row_model(rct_pkg::ACT_CLEAR, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_beat(script[i].act, script[i].old_h, script[i].new_h,
                      script[i].typed, script[i].want);

        // Random part. Each episode picks at random between growing the table, which fills it and
        // exercises the full and duplicate rejections, and churning references, which
        // drives counts up and down and releases entries.
        grow = 1'b1;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idle_pct = phase_idle(p);
            for (int k = 0; k < BEATS_PER_PHASE; k++)
            begin
                if (k % 80 == 0)
                    grow = 1'($urandom_range(1));
                roll = $urandom_range(99);
                old_h = $urandom();
                new_h = $urandom();
                if (roll < (grow ? 70 : 35))
                begin
                    act = rct_pkg::ACT_REGISTER;
                    new_h = pick_handle(25);
                end
                else if (roll < (grow ? 96 : 93))
                begin
                    act = rct_pkg::ACT_ASSIGN;
                    old_h = pick_handle(75);
                    new_h = ($urandom_range(9) == 0) ? old_h : pick_handle(70);
                end
                else if (roll < (grow ? 97 : 96))
                    act = rct_pkg::ACT_CLEAR;
                else
                    act = rct_pkg::ACT_NONE;
                send_beat(act, old_h, new_h, 1'b0, '0);
            end
        end

        // Drain: every owed outcome must arrive, then a quiet stretch of one full command
        // time catches any stray result beat.
        while (owed_outcomes.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);

        $display("Checked %0d results: %0d register, %0d assign, %0d clear, %0d unused beats.",
                 n_checked, n_by_action[rct_pkg::ACT_REGISTER],
                 n_by_action[rct_pkg::ACT_ASSIGN], n_by_action[rct_pkg::ACT_CLEAR],
                 n_by_action[rct_pkg::ACT_NONE]);
        $display("Full rejects %0d, duplicates %0d, releases %0d, cleared %0d, peak live %0d.",
                 n_full, n_dup, n_release, n_cleared, peak_live);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Watchdog: counts cycles in which neither a command beat nor a result beat is taken.
    always @(posedge clk)
    begin
        if (rst_n && !(start && !busy) && !done)
            stall_cycles = stall_cycles + 1;
        else
            stall_cycles = 0;
        if (stall_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/rct_pkg.sv
hw/rtl/rct_ctrl.sv
hw/rtl/rct_datapath.sv
hw/rtl/reference_count_table_core.sv
hw/rtl/rct_checker.sv
tb/tb_top.sv
